// ===== design/two_button_long_press_chord_assert.svh =====
// assertion macros for the chord detector checker
`ifndef TWO_BUTTON_LONG_PRESS_CHORD_ASSERT_SVH
`define TWO_BUTTON_LONG_PRESS_CHORD_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TBLPC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define TBLPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/tblpc_pkg.sv =====
// shared types and constants for the two-button chord detector
`default_nettype none

package tblpc_pkg;

   localparam int unsigned StampWidth  = 32;
   localparam int unsigned WindowWidth = 16;
   localparam int unsigned CsrIdxWidth = 2;

   localparam logic [WindowWidth-1:0] JoinWindowReset    = 16'd400;
   localparam logic [WindowWidth-1:0] HoldTimeReset      = 16'd3000;
   localparam logic [WindowWidth-1:0] ReleaseWindowReset = 16'd400;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_JOIN_WINDOW    = 2'd0,
      CSR_HOLD_TIME      = 2'd1,
      CSR_RELEASE_WINDOW = 2'd2
   } csr_idx_type;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_ONE_DOWN = 3'd1,
      PH_BOTH     = 3'd2,
      PH_HELD     = 3'd3,
      PH_RELEASED = 3'd4
   } phase_type;

   typedef struct packed {
      logic                  left_pressed;
      logic                  right_pressed;
      logic [StampWidth-1:0] time_ms;
   } sample_type;

   typedef struct packed {
      logic [WindowWidth-1:0] join_window_ms;
      logic [WindowWidth-1:0] hold_time_ms;
      logic [WindowWidth-1:0] release_window_ms;
   } cfg_type;

   typedef struct packed {
      logic      close_request;
      phase_type phase;
   } result_type;

endpackage

`default_nettype wire

// ===== design/two_button_long_press_chord.sv =====
// top level of the two-button chord long-press detector
// path: from the accepting edge to the earliest result accept, an item passes the
//   input register, then the result register
// throughput: one item per cycle; the phase update fits between the two registers
// a waiting result stalls intake once the input register holds an item
// reset: synchronous, active high; phase idle, registers 400 / 3000 / 400 ms
`default_nettype none

module two_button_long_press_chord (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // sample channel
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_left_pressed,
   input  wire logic                               req_right_pressed,
   input  wire logic [tblpc_pkg::StampWidth-1:0]   req_time_ms,
   // result channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_close_request,
   output logic [2:0]                              rsp_phase,
   // register write channel
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [tblpc_pkg::CsrIdxWidth-1:0]  csr_index,
   input  wire logic [tblpc_pkg::WindowWidth-1:0]  csr_data
);

   tblpc_pkg::sample_type  sample_ff, sample_in;
   logic                   s1_valid_ff, s1_valid_in;
   tblpc_pkg::result_type  rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   tblpc_pkg::cfg_type     cfg;
   tblpc_pkg::result_type  step_result;
   logic                   advance;
   logic                   fire;
   logic                   req_fire;

   // result slot free or being drained this cycle
   assign advance   = !rsp_valid_ff || rsp_ready;
   // item in the input register moves through the phase logic
   assign fire      = s1_valid_ff && advance;
   assign req_ready = !s1_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   tblpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tblpc_step u_step (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .sample (sample_ff),
      .cfg    (cfg),
      .result (step_result)
   );

   // input register
   always_comb begin
      sample_in               = sample_ff;
      sample_in.left_pressed  = req_left_pressed;
      sample_in.right_pressed = req_right_pressed;
      sample_in.time_ms       = req_time_ms;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // result register
   always_comb begin
      rsp_in = step_result;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         sample_ff <= sample_in;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_close_request = rsp_ff.close_request;
   assign rsp_phase         = rsp_ff.phase;

endmodule

`default_nettype wire

// ===== design/tblpc_csr.sv =====
// configuration registers: join window, hold time, release window
`default_nettype none

module tblpc_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [tblpc_pkg::CsrIdxWidth-1:0]    csr_index,
   input  wire logic [tblpc_pkg::WindowWidth-1:0]    csr_data,
   output tblpc_pkg::cfg_type                        cfg
);

   tblpc_pkg::cfg_type cfg_ff;
   tblpc_pkg::cfg_type cfg_in;
   logic               wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid & csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_index)
            tblpc_pkg::CSR_JOIN_WINDOW:    cfg_in.join_window_ms    = csr_data;
            tblpc_pkg::CSR_HOLD_TIME:      cfg_in.hold_time_ms      = csr_data;
            tblpc_pkg::CSR_RELEASE_WINDOW: cfg_in.release_window_ms = csr_data;
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.join_window_ms    <= tblpc_pkg::JoinWindowReset;
         cfg_ff.hold_time_ms      <= tblpc_pkg::HoldTimeReset;
         cfg_ff.release_window_ms <= tblpc_pkg::ReleaseWindowReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== design/tblpc_step.sv =====
// gesture phase machine with its timestamp registers
`default_nettype none

module tblpc_step (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   fire,
   input  wire tblpc_pkg::sample_type  sample,
   input  wire tblpc_pkg::cfg_type     cfg,
   output tblpc_pkg::result_type       result
);

   tblpc_pkg::phase_type                phase_ff, phase_in;
   logic [tblpc_pkg::StampWidth-1:0]    first_press_ff, first_press_in;
   logic [tblpc_pkg::StampWidth-1:0]    both_press_ff, both_press_in;
   logic [tblpc_pkg::StampWidth-1:0]    first_release_ff, first_release_in;
   logic [tblpc_pkg::StampWidth-1:0]    join_elapsed, hold_elapsed, release_elapsed;
   logic                                any_down, both_down;
   logic                                close_req;

   assign any_down  = sample.left_pressed | sample.right_pressed;
   assign both_down = sample.left_pressed & sample.right_pressed;

   // wrapping elapsed times
   assign join_elapsed    = sample.time_ms - first_press_ff;
   assign hold_elapsed    = sample.time_ms - both_press_ff;
   assign release_elapsed = sample.time_ms - first_release_ff;

   always_comb begin
      phase_in         = phase_ff;
      first_press_in   = first_press_ff;
      both_press_in    = both_press_ff;
      first_release_in = first_release_ff;
      close_req        = 1'b0;
      case (phase_ff)
         tblpc_pkg::PH_IDLE: begin
            if (any_down) begin
               first_press_in = sample.time_ms;
               phase_in       = tblpc_pkg::PH_ONE_DOWN;
            end
         end
         tblpc_pkg::PH_ONE_DOWN: begin
            if (both_down) begin
               both_press_in = sample.time_ms;
               phase_in      = tblpc_pkg::PH_BOTH;
            end else if (!any_down) begin
               phase_in = tblpc_pkg::PH_IDLE;
            end else if (join_elapsed >
                         {{(tblpc_pkg::StampWidth-tblpc_pkg::WindowWidth){1'b0}},
                          cfg.join_window_ms}) begin
               phase_in = tblpc_pkg::PH_IDLE;
            end
         end
         tblpc_pkg::PH_BOTH: begin
            if (!both_down) begin
               phase_in = tblpc_pkg::PH_IDLE;
            end else if (hold_elapsed >=
                         {{(tblpc_pkg::StampWidth-tblpc_pkg::WindowWidth){1'b0}},
                          cfg.hold_time_ms}) begin
               phase_in = tblpc_pkg::PH_HELD;
            end
         end
         tblpc_pkg::PH_HELD: begin
            if (!both_down) begin
               first_release_in = sample.time_ms;
               phase_in         = tblpc_pkg::PH_RELEASED;
            end
         end
         tblpc_pkg::PH_RELEASED: begin
            if (!any_down) begin
               close_req = 1'b1;
               phase_in  = tblpc_pkg::PH_IDLE;
            end else if (release_elapsed >
                         {{(tblpc_pkg::StampWidth-tblpc_pkg::WindowWidth){1'b0}},
                          cfg.release_window_ms}) begin
               phase_in = tblpc_pkg::PH_IDLE;
            end
         end
         default: begin
            phase_in = tblpc_pkg::PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tblpc_pkg::PH_IDLE;
      end else if (fire) begin
         phase_ff <= phase_in;
      end
   end

   // stamps are always written before they are read
   always_ff @(posedge clock) begin
      if (fire) begin
         first_press_ff   <= first_press_in;
         both_press_ff    <= both_press_in;
         first_release_ff <= first_release_in;
      end
   end

   assign result.close_request = close_req;
   assign result.phase         = phase_in;

endmodule

`default_nettype wire

// ===== design/tblpc_checker.sv =====
// port-level checker for the chord detector, bound to the top level
`default_nettype none

`include "two_button_long_press_chord_assert.svh"

module tblpc_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_ready,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic                               rsp_close_request,
   input wire logic [2:0]                         rsp_phase
);

   // a completed chord always lands back in idle
   `TBLPC_ASSERT_NOW(a_close_is_idle, clock, reset,
      rsp_valid && rsp_close_request,
      rsp_phase == tblpc_pkg::PH_IDLE,
      "close request with non-idle phase")

   // with the result slot empty, intake is never blocked
   `TBLPC_ASSERT_NOW(a_ready_when_empty, clock, reset,
      !rsp_valid,
      req_ready,
      "sample channel stalled with no result pending")

   // an item after an idle result can only stay idle or see one button down
   `TBLPC_ASSERT_NEXT(a_after_idle, clock, reset,
      rsp_valid && rsp_ready && rsp_phase == tblpc_pkg::PH_IDLE,
      !rsp_valid || (!rsp_close_request && (rsp_phase == tblpc_pkg::PH_IDLE ||
                                            rsp_phase == tblpc_pkg::PH_ONE_DOWN)),
      "illegal phase step after idle")

   // a stalled result holds
   `TBLPC_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_phase) && $stable(rsp_close_request),
      "stalled result changed")

endmodule

bind two_button_long_press_chord tblpc_checker u_tblpc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_close_request (rsp_close_request),
   .rsp_phase         (rsp_phase)
);

`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for the two-button chord long-press detector
`timescale 1ns / 1ps

module tb;

   // register index that decodes to nothing
   localparam logic [tblpc_pkg::CsrIdxWidth-1:0] CsrIdxUnused = 2'd3;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic                              req_left_pressed = 1'b0;
   logic                              req_right_pressed = 1'b0;
   logic [tblpc_pkg::StampWidth-1:0]  req_time_ms = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic                              rsp_close_request;
   logic [2:0]                        rsp_phase;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [tblpc_pkg::CsrIdxWidth-1:0] csr_index = '0;
   logic [tblpc_pkg::WindowWidth-1:0] csr_data = '0;

   two_button_long_press_chord i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_left_pressed  (req_left_pressed),
      .req_right_pressed (req_right_pressed),
      .req_time_ms       (req_time_ms),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_close_request (rsp_close_request),
      .rsp_phase         (rsp_phase),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // gesture tracker state, mirrors the block after reset
   tblpc_pkg::phase_type gesture_now  = tblpc_pkg::PH_IDLE;
   logic [31:0]          press_mark   = '0;
   logic [31:0]          chord_mark   = '0;
   logic [31:0]          release_mark = '0;
   tblpc_pkg::cfg_type   window_cfg   = '{join_window_ms:    tblpc_pkg::JoinWindowReset,
                                          hold_time_ms:      tblpc_pkg::HoldTimeReset,
                                          release_window_ms: tblpc_pkg::ReleaseWindowReset};

   tblpc_pkg::sample_type sample_backlog[$];     // samples waiting to be driven
   tblpc_pkg::result_type chord_results_due[$];  // predicted results, oldest first

   int               idle_pct        = 32;
   int               mismatches      = 0;
   int               results_checked = 0;
   int               closes_seen     = 0;
   int               samples_taken   = 0;
   int               samples_queued  = 0;
   int               reg_writes      = 0;
   logic [31:0]      stamp_now       = '0;  // running timestamp for generated samples

   // one step of the chord gesture, returns close flag and the new phase
   function automatic tblpc_pkg::result_type advance_gesture(input logic left,
                                                             input logic right,
                                                             input logic [31:0] now);
      tblpc_pkg::result_type res;
      logic [31:0]           elapsed;
      res.close_request = 1'b0;
      case (gesture_now)
         tblpc_pkg::PH_IDLE: begin
            // a single press or both at once only gets to one-down
            if (left || right) begin
               press_mark  = now;
               gesture_now = tblpc_pkg::PH_ONE_DOWN;
            end
         end
         tblpc_pkg::PH_ONE_DOWN: begin
            elapsed = now - press_mark;
            if (left && right) begin
               chord_mark  = now;
               gesture_now = tblpc_pkg::PH_BOTH;
            end else if (!left && !right) begin
               gesture_now = tblpc_pkg::PH_IDLE;
            end else if (elapsed > {16'd0, window_cfg.join_window_ms}) begin
               gesture_now = tblpc_pkg::PH_IDLE;
            end
         end
         tblpc_pkg::PH_BOTH: begin
            elapsed = now - chord_mark;
            if (!left || !right) begin
               gesture_now = tblpc_pkg::PH_IDLE;
            end else if (elapsed >= {16'd0, window_cfg.hold_time_ms}) begin
               gesture_now = tblpc_pkg::PH_HELD;
            end
         end
         tblpc_pkg::PH_HELD: begin
            // either or both buttons up starts the release window
            if (!left || !right) begin
               release_mark = now;
               gesture_now  = tblpc_pkg::PH_RELEASED;
            end
         end
         tblpc_pkg::PH_RELEASED: begin
            // a re-press here does not abort, only the window does
            elapsed = now - release_mark;
            if (!left && !right) begin
               res.close_request = 1'b1;
               gesture_now       = tblpc_pkg::PH_IDLE;
            end else if (elapsed > {16'd0, window_cfg.release_window_ms}) begin
               gesture_now = tblpc_pkg::PH_IDLE;
            end
         end
         default: gesture_now = tblpc_pkg::PH_IDLE;
      endcase
      res.phase = gesture_now;
      return res;
   endfunction

   task automatic note_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", what);
   endtask

   // sample driver: offers the next pending item when the channel is free, unless a random gap is drawn
   always @(posedge clock) begin
      tblpc_pkg::sample_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            chord_results_due.push_back(
               advance_gesture(req_left_pressed, req_right_pressed, req_time_ms));
            samples_taken++;
         end
         if (!req_valid || req_ready) begin
            if (sample_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               nxt = sample_backlog.pop_front();
               req_valid         <= 1'b1;
               req_left_pressed  <= nxt.left_pressed;
               req_right_pressed <= nxt.right_pressed;
               req_time_ms       <= nxt.time_ms;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor: random back-pressure, compares against the oldest prediction
   always @(posedge clock) begin
      tblpc_pkg::result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (rsp_close_request === 1'b1) closes_seen++;
            if (chord_results_due.size() == 0) begin
               note_mismatch($sformatf("unexpected result close %0b phase %0d",
                                       rsp_close_request, rsp_phase));
            end else begin
               want = chord_results_due.pop_front();
               if (rsp_close_request !== want.close_request || rsp_phase !== want.phase)
                  note_mismatch($sformatf(
                     "result %0d expected close %0b phase %0d, got close %0b phase %0d",
                     results_checked, want.close_request, want.phase,
                     rsp_close_request, rsp_phase));
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= idle_pct);
      end
   end

   // register write, valid goes low again between writes
   task automatic write_reg(input logic [tblpc_pkg::CsrIdxWidth-1:0] idx,
                            input logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      reg_writes++;
      case (idx)
         tblpc_pkg::CSR_JOIN_WINDOW:    window_cfg.join_window_ms    = val;
         tblpc_pkg::CSR_HOLD_TIME:      window_cfg.hold_time_ms      = val;
         tblpc_pkg::CSR_RELEASE_WINDOW: window_cfg.release_window_ms = val;
         default: ;  // unused index, nothing changes
      endcase
   endtask

   task automatic push_sample(input logic left, input logic right, input logic [31:0] at);
      tblpc_pkg::sample_type s;
      s.left_pressed  = left;
      s.right_pressed = right;
      s.time_ms       = at;
      sample_backlog.push_back(s);
      samples_queued++;
   endtask

   // elapsed time around a window: inside, on the edge, one past, or anywhere up to well past
   function automatic logic [31:0] pick_gap(input logic [15:0] window);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return $urandom_range(0, window);
      if (roll < 70) return {16'd0, window};
      if (roll < 85) return {16'd0, window} + 32'd1;
      return $urandom_range(0, 3 * window + 10);
   endfunction

   // one chord attempt with random timing, mostly well formed
   task automatic push_gesture();
      logic        lead_left;
      logic [31:0] held_from;
      logic [31:0] let_go;
      logic [31:0] hold;
      int          roll;
      hold      = {16'd0, window_cfg.hold_time_ms};
      lead_left = 1'($urandom_range(0, 1));
      stamp_now += $urandom_range(1, 5000);
      if ($urandom_range(0, 9) == 0) push_sample(1'b1, 1'b1, stamp_now);
      else push_sample(lead_left, !lead_left, stamp_now);
      // sometimes the lone button is sampled again before the join
      if ($urandom_range(0, 3) == 0) begin
         stamp_now += $urandom_range(0, window_cfg.join_window_ms / 2);
         push_sample(lead_left, !lead_left, stamp_now);
      end
      stamp_now += pick_gap(window_cfg.join_window_ms);
      push_sample(1'b1, 1'b1, stamp_now);
      held_from = stamp_now;
      repeat ($urandom_range(0, 3)) begin
         stamp_now += $urandom_range(0, hold / 4);
         push_sample(1'b1, 1'b1, stamp_now);
      end
      // occasional early drop during the hold
      if ($urandom_range(0, 9) == 0) begin
         stamp_now += $urandom_range(0, 100);
         push_sample(!lead_left, lead_left, stamp_now);
         return;
      end
      roll = $urandom_range(0, 99);
      if (roll < 70) stamp_now = held_from + hold + $urandom_range(0, 20);
      else if (roll < 85) stamp_now = held_from + hold - ((hold != 0) ? 32'd1 : 32'd0);
      else stamp_now = held_from + $urandom_range(0, 2 * hold + 10);
      push_sample(1'b1, 1'b1, stamp_now);
      if ($urandom_range(0, 3) == 0) begin
         stamp_now += $urandom_range(0, 300);
         push_sample(1'b1, 1'b1, stamp_now);
      end
      // first release, both together now and then
      stamp_now += $urandom_range(0, 200);
      let_go = stamp_now;
      if ($urandom_range(0, 99) < 15) push_sample(1'b0, 1'b0, stamp_now);
      else push_sample(!lead_left, lead_left, stamp_now);
      if ($urandom_range(0, 4) == 0) begin
         stamp_now += $urandom_range(0, window_cfg.release_window_ms / 2);
         push_sample(1'b1, 1'b1, stamp_now);
      end
      stamp_now = let_go + pick_gap(window_cfg.release_window_ms);
      if ($urandom_range(0, 99) < 85) push_sample(1'b0, 1'b0, stamp_now);
      else push_sample(!lead_left, lead_left, stamp_now);
   endtask

   // random levels, times either jumping anywhere or creeping forward
   task automatic push_noise();
      repeat ($urandom_range(1, 4)) begin
         if ($urandom_range(0, 1)) stamp_now = $urandom;
         else stamp_now += $urandom_range(0, 600);
         push_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), stamp_now);
      end
   endtask

   // wait at falling edges until every sample is in and every result checked
   task automatic wait_drained();
      while (sample_backlog.size() != 0 || req_valid || chord_results_due.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // one configuration setting followed by random gestures and noise
   task automatic run_block(input logic [15:0] join_ms, input logic [15:0] hold_ms,
                            input logic [15:0] release_ms, input int count,
                            input logic no_gaps);
      int target;
      write_reg(tblpc_pkg::CSR_JOIN_WINDOW, join_ms);
      write_reg(tblpc_pkg::CSR_HOLD_TIME, hold_ms);
      write_reg(tblpc_pkg::CSR_RELEASE_WINDOW, release_ms);
      @(negedge clock);
      idle_pct  = no_gaps ? 0 : 32;
      stamp_now = $urandom;
      target    = samples_queued + count;
      while (samples_queued < target) begin
         if ($urandom_range(0, 99) < 75) push_gesture();
         else push_noise();
      end
      wait_drained();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed samples at the reset windows of 400 / 3000 / 400 ms
      push_sample(1'b0, 1'b0, 32'h0000_0000);            // nothing pressed
      push_sample(1'b1, 1'b0, 32'hFFFF_FF00);            // left down just before wrap
      push_sample(1'b1, 1'b1, 32'h0000_0050);            // join across the wrap
      push_sample(1'b1, 1'b1, 32'h0000_0050 + 32'd2999); // one ms short of hold
      push_sample(1'b1, 1'b1, 32'h0000_0050 + 32'd3000); // hold met exactly
      push_sample(1'b0, 1'b1, 32'h0000_1000);            // left released first
      push_sample(1'b1, 1'b1, 32'h0000_1064);            // re-press keeps the gesture
      push_sample(1'b0, 1'b0, 32'h0000_1190);            // second release on the edge
      push_sample(1'b1, 1'b1, 32'h0001_0000);            // both at once from idle
      push_sample(1'b1, 1'b1, 32'h0001_0000);            // both held, no time passed
      push_sample(1'b1, 1'b0, 32'h0001_0010);            // drop during hold
      push_sample(1'b0, 1'b1, 32'h0002_0000);            // right alone
      push_sample(1'b0, 1'b1, 32'h0002_0191);            // join window missed by one
      push_sample(1'b1, 1'b0, 32'h0003_0000);
      push_sample(1'b0, 1'b0, 32'h0003_0001);            // let go before the join
      push_sample(1'b0, 1'b1, 32'h0004_0000);
      push_sample(1'b1, 1'b1, 32'h0004_0190);            // join on the edge
      push_sample(1'b1, 1'b1, 32'h0004_0190 + 32'd3000);
      push_sample(1'b0, 1'b0, 32'h0004_1000);            // both released together
      push_sample(1'b0, 1'b0, 32'hFFFF_FFFF);            // none down closes even late
      push_sample(1'b1, 1'b0, 32'h0005_0000);
      push_sample(1'b1, 1'b1, 32'h0005_0100);
      push_sample(1'b1, 1'b1, 32'h0005_0100 + 32'd3000);
      push_sample(1'b1, 1'b0, 32'h0005_1000);            // right released first
      push_sample(1'b1, 1'b0, 32'h0005_1191);            // release window missed by one
      wait_drained();

      // mid-range windows with both sides running flat out
      run_block(16'd120, 16'd900, 16'd150, 100, 1'b1);
      // zero windows and zero hold
      run_block(16'd0, 16'd0, 16'd0, 60, 1'b0);
      // widest windows
      run_block(16'hFFFF, 16'hFFFF, 16'hFFFF, 60, 1'b0);
      // a write to the unused index must leave the windows alone
      write_reg(CsrIdxUnused, 16'hFFFF);
      run_block(16'($urandom_range(0, 50)), 16'($urandom_range(0, 200)),
                16'($urandom_range(0, 50)), 90, 1'b0);
      // back to the reset values
      run_block(tblpc_pkg::JoinWindowReset, tblpc_pkg::HoldTimeReset,
                tblpc_pkg::ReleaseWindowReset, 90, 1'b0);

      repeat (10) @(posedge clock);
      $display("summary: %0d samples sent, %0d results checked, %0d chord closes",
               samples_taken, results_checked, closes_seen);
      $display("summary: %0d register writes over six window settings, %0d mismatches",
               reg_writes, mismatches);
      if (mismatches == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("tb NOT OK");
      $finish;
   end

endmodule
